/* sv/smi_pkg.sv */
// Shared types, constants and fixed-point helpers for the stochastic momentum index.
// No dependencies; the configuration, window, divider, fraction and top files import this package.
`timescale 1ns / 1ps

package smi_pkg;

  localparam int MaxWindow = 64;
  localparam int WinAw     = $clog2(MaxWindow);
  localparam int PriceBits = 32;
  localparam int FracBits  = 24;
  localparam int AccBits   = 56;
  localparam int SumBits   = 64;
  localparam int OutBits   = 24;
  localparam int PaddrW    = 5;
  localparam int NumOps    = 5;
  localparam int Q16Limit  = 6553600;

  typedef logic signed [AccBits-1:0] acc_t;
  typedef logic signed [SumBits-1:0] sum_t;
  typedef logic signed [OutBits-1:0] q16_t;

  localparam acc_t AccMax = {1'b0, {(AccBits-1){1'b1}}};
  localparam acc_t AccMin = {1'b1, {(AccBits-1){1'b0}}};
  localparam sum_t SumMax = {1'b0, {(SumBits-1){1'b1}}};
  localparam sum_t SumMin = {1'b1, {(SumBits-2){1'b0}}, 1'b1};
  localparam acc_t SmiFull = acc_t'(100) <<< FracBits;

  localparam logic [2:0] RegWinLen = 3'd0;
  localparam logic [2:0] RegSlow   = 3'd1;
  localparam logic [2:0] RegFast   = 3'd2;
  localparam logic [2:0] RegSignal = 3'd3;
  localparam logic [2:0] RegExtra  = 3'd4;

  typedef struct packed {
    logic [6:0] win_len;
    logic [7:0] slow_p;
    logic [7:0] fast_p;
    logic [7:0] sig_p;
    logic [7:0] extra;
  } cfg_t;

  typedef struct packed {
    logic                 store;
    logic                 clear;
    logic [PriceBits-1:0] high;
    logic [PriceBits-1:0] low;
    logic                 scan;
    logic [WinAw:0]       len;
  } win_req_t;

  typedef struct packed {
    logic [WinAw:0]       fill;
    logic                 done;
    logic [PriceBits-1:0] high;
    logic [PriceBits-1:0] low;
  } win_rsp_t;

  function automatic acc_t clamp_acc(input sum_t v);
    acc_t r;
    if (v > sum_t'(AccMax)) begin
      r = AccMax;
    end else if (v < sum_t'(AccMin)) begin
      r = AccMin;
    end else begin
      r = v[AccBits-1:0];
    end
    return r;
  endfunction

  function automatic sum_t sat_add(input sum_t a, input sum_t b);
    logic signed [SumBits:0] s;
    logic signed [SumBits:0] lim;
    sum_t r;
    lim = {1'b0, SumMax};
    s = {a[SumBits-1], a} + {b[SumBits-1], b};
    if (s > lim) begin
      r = SumMax;
    end else if (s < -lim) begin
      r = SumMin;
    end else begin
      r = s[SumBits-1:0];
    end
    return r;
  endfunction

  function automatic q16_t to_q16(input acc_t v);
    logic [AccBits-1:0] m;
    logic [AccBits:0]   q;
    logic [OutBits-1:0] u;
    m = v[AccBits-1] ? AccBits'(-v) : AccBits'(v);
    q = ({1'b0, m} + (AccBits+1)'(1 << (FracBits - 17))) >> (FracBits - 16);
    if (q > (AccBits+1)'(Q16Limit)) begin
      u = OutBits'(Q16Limit);
    end else begin
      u = q[OutBits-1:0];
    end
    return v[AccBits-1] ? q16_t'(-u) : q16_t'(u);
  endfunction

  function automatic logic [7:0] eff_period(input logic [7:0] p);
    return (p == 8'd0) ? 8'd1 : p;
  endfunction

endpackage

/* sv/smi_if.sv */
// Handshake channels of the stochastic momentum index: price bars in, results out.
// Depends on nothing but the port widths of the bar and result words.
`timescale 1ns / 1ps

interface smi_bar_if;
  logic        valid;
  logic        ready;
  logic [31:0] bar_high;
  logic [31:0] bar_low;
  logic [31:0] bar_close;
  logic        restart;
  logic        last_bar;
  modport source (output valid, bar_high, bar_low, bar_close, restart, last_bar,
                  input ready);
  modport sink (input valid, bar_high, bar_low, bar_close, restart, last_bar,
                output ready);
endinterface

interface smi_res_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] smi_line;
  logic signed [23:0] signal_line;
  logic [31:0]        bar_index;
  logic [31:0]        out_count;
  logic               final_res;
  modport source (output valid, smi_line, signal_line, bar_index, out_count, final_res,
                  input ready);
  modport sink (input valid, smi_line, signal_line, bar_index, out_count, final_res,
                output ready);
endinterface

/* sv/smi_cfg.sv */
// APB configuration registers of the stochastic momentum index.
// Depends on smi_pkg for the register indexes and the settings struct.
`timescale 1ns / 1ps

module smi_cfg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [smi_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output smi_pkg::cfg_t             cfg_o
);
  import smi_pkg::*;

  cfg_t       cfg_q;
  logic [2:0] idx;

  assign idx    = paddr[PaddrW-1:2];
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{win_len: 7'd10, slow_p: 8'd3, fast_p: 8'd3, sig_p: 8'd3, extra: 8'd0};
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        RegWinLen: cfg_q.win_len <= pwdata[6:0];
        RegSlow:   cfg_q.slow_p  <= pwdata[7:0];
        RegFast:   cfg_q.fast_p  <= pwdata[7:0];
        RegSignal: cfg_q.sig_p   <= pwdata[7:0];
        RegExtra:  cfg_q.extra   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegWinLen: prdata = {25'd0, cfg_q.win_len};
      RegSlow:   prdata = {24'd0, cfg_q.slow_p};
      RegFast:   prdata = {24'd0, cfg_q.fast_p};
      RegSignal: prdata = {24'd0, cfg_q.sig_p};
      RegExtra:  prdata = {24'd0, cfg_q.extra};
      default:   prdata = 32'd0;
    endcase
  end

endmodule

/* sv/smi_win.sv */
// Ring buffer of bar highs and lows in one synchronous memory, with the extremes scan.
// Depends on smi_pkg for the window depth and the request and response structs.
`timescale 1ns / 1ps

module smi_win (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  smi_pkg::win_req_t req_i,
  output smi_pkg::win_rsp_t rsp_o
);
  import smi_pkg::*;

  logic [2*PriceBits-1:0] mem [MaxWindow];
  logic [2*PriceBits-1:0] rd_q;
  logic [WinAw-1:0]       slot_q, wr_slot, base_q, rd_addr;
  logic [WinAw:0]         fill_q, fill_base, cnt_q;
  logic                   busy_q, rvld_q, rfirst_q, rlast_q, done_q, issue_last;
  logic [PriceBits-1:0]   hi_q, lo_q, rd_hi, rd_lo;

  assign wr_slot    = req_i.clear ? '0 : slot_q;
  assign fill_base  = req_i.clear ? '0 : fill_q;
  assign rd_addr    = base_q + cnt_q[WinAw-1:0];
  assign issue_last = (cnt_q == req_i.len - (WinAw+1)'(1));
  assign rd_hi      = rd_q[2*PriceBits-1:PriceBits];
  assign rd_lo      = rd_q[PriceBits-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q   <= '0;
      fill_q   <= '0;
      busy_q   <= 1'b0;
      cnt_q    <= '0;
      base_q   <= '0;
      rvld_q   <= 1'b0;
      rfirst_q <= 1'b0;
      rlast_q  <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      if (req_i.store) begin
        slot_q <= wr_slot + WinAw'(1);
        fill_q <= (fill_base == (WinAw+1)'(MaxWindow)) ? fill_base : fill_base + 1'b1;
      end
      if (req_i.scan) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        base_q <= slot_q - req_i.len[WinAw-1:0];
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (issue_last) begin
          busy_q <= 1'b0;
        end
      end
      rvld_q   <= busy_q;
      rfirst_q <= busy_q && (cnt_q == '0);
      rlast_q  <= busy_q && issue_last;
      done_q   <= rvld_q && rlast_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.store) begin
      mem[wr_slot] <= {req_i.high, req_i.low};
    end
    if (busy_q) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rvld_q) begin
      if (rfirst_q || rd_hi > hi_q) begin
        hi_q <= rd_hi;
      end
      if (rfirst_q || rd_lo < lo_q) begin
        lo_q <= rd_lo;
      end
    end
  end

  assign rsp_o = '{fill: fill_q, done: done_q, high: hi_q, low: lo_q};

endmodule

/* sv/smi_div.sv */
// Iterative rounding divider: signed 64-bit dividend over a small period, four bits a cycle.
// Depends on smi_pkg for the wide sum type.
`timescale 1ns / 1ps

module smi_div (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  smi_pkg::sum_t num_i,
  input  logic [8:0]    den_i,
  output logic          done_o,
  output smi_pkg::sum_t quo_o
);
  import smi_pkg::*;

  localparam int Radix = 4;
  localparam int Steps = SumBits / Radix;

  logic [SumBits-1:0]           dvd_q, quo_q, dvd_n, quo_n, mag;
  logic [8:0]                   rem_q, den_q, rem_n;
  logic [$clog2(Steps)-1:0]     cnt_q;
  logic                         busy_q, neg_q, done_q;

  assign mag = num_i[SumBits-1] ? SumBits'(-num_i) : SumBits'(num_i);

  always_comb begin
    logic [9:0] t;
    rem_n = rem_q;
    dvd_n = dvd_q;
    quo_n = quo_q;
    for (int i = 0; i < Radix; i++) begin
      t     = {rem_n, dvd_n[SumBits-1]};
      dvd_n = dvd_n << 1;
      if (t >= {1'b0, den_q}) begin
        rem_n = 9'(t - {1'b0, den_q});
        quo_n = {quo_n[SumBits-2:0], 1'b1};
      end else begin
        rem_n = t[8:0];
        quo_n = {quo_n[SumBits-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == ($clog2(Steps))'(Steps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= mag + SumBits'(den_i >> 1);
      den_q <= den_i;
      neg_q <= num_i[SumBits-1];
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_n;
      rem_q <= rem_n;
      quo_q <= quo_n;
    end
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? sum_t'(-quo_q) : sum_t'(quo_q);

endmodule

/* sv/smi_frac.sv */
// SMI line from the fast numerator and denominator: bit-serial fraction, scale and round.
// Depends on smi_pkg for the internal fixed-point type.
`timescale 1ns / 1ps

module smi_frac (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  smi_pkg::acc_t num_i,
  input  smi_pkg::acc_t den_i,
  output logic          done_o,
  output smi_pkg::acc_t smi_o
);
  import smi_pkg::*;

  localparam int FBits = 40;
  localparam logic [1:0] FrIdle = 2'd0;
  localparam logic [1:0] FrLoop = 2'd1;
  localparam logic [1:0] FrMul  = 2'd2;
  localparam logic [1:0] FrRnd  = 2'd3;

  logic [1:0]               st_q;
  logic [AccBits-2:0]       r_q, d_q;
  logic [AccBits-1:0]       a;
  logic [AccBits-1:0]       t;
  logic [FBits-1:0]         f_q;
  logic [FBits+7:0]         prod_q;
  logic [31:0]              s;
  logic [$clog2(FBits)-1:0] cnt_q;
  logic                     neg_q, done_q, ge;
  acc_t                     res_q;

  assign a  = num_i[AccBits-1] ? AccBits'(-num_i) : AccBits'(num_i);
  assign t  = {r_q, 1'b0};
  assign ge = (t >= {1'b0, d_q});
  assign s  = 32'((prod_q + (FBits+8)'(1 << (FBits - FracBits - 1))) >> (FBits - FracBits));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= FrIdle;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (st_q)
        FrIdle: begin
          if (start_i) begin
            if (den_i[AccBits-1] || den_i == '0) begin
              done_q <= 1'b1;
            end else if ({a, 1'b0} >= {2'b00, den_i[AccBits-2:0]}) begin
              done_q <= 1'b1;
            end else begin
              cnt_q <= '0;
              st_q  <= FrLoop;
            end
          end
        end
        FrLoop: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == ($clog2(FBits))'(FBits - 1)) begin
            st_q <= FrMul;
          end
        end
        FrMul: st_q <= FrRnd;
        FrRnd: begin
          st_q   <= FrIdle;
          done_q <= 1'b1;
        end
        default: st_q <= FrIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      FrIdle: begin
        if (start_i) begin
          neg_q <= num_i[AccBits-1];
          d_q   <= den_i[AccBits-2:0];
          r_q   <= a[AccBits-2:0];
          f_q   <= '0;
          if (den_i[AccBits-1] || den_i == '0) begin
            res_q <= '0;
          end else begin
            res_q <= num_i[AccBits-1] ? -SmiFull : SmiFull;
          end
        end
      end
      FrLoop: begin
        r_q <= ge ? (AccBits-1)'(t - {1'b0, d_q}) : t[AccBits-2:0];
        f_q <= {f_q[FBits-2:0], ge};
      end
      FrMul: prod_q <= (FBits+8)'(f_q) * (FBits+8)'(200);
      FrRnd: res_q <= neg_q ? -acc_t'(s) : acc_t'(s);
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign smi_o  = res_q;

endmodule

/* sv/stochastic_momentum_index.sv */
// Stochastic momentum index: bar window, smoothing stages, SMI and signal line.
// Uses smi_pkg, the channel interfaces, smi_cfg, smi_win, smi_div and smi_frac.
//
// Price bars enter on bar_in, one word per accepted handshake; results leave on
// res_out. The user must write settings over the APB port only while no bar is
// in flight; the block itself does not enforce this. A bar is taken only while
// the block is idle. Each bar is written into the window memory; once the window
// holds window_length bars the memory is read back one entry a cycle to find the
// extremes. The five smoothing updates then run in turn through one shared
// rounding divider; an update that only accumulates a seed sum skips it. Before
// the signal-line update, the SMI line comes from the bit-serial fraction unit.
// A result stands in an output register until it is taken; the next bar is
// accepted meanwhile, and it waits at its end only while that register is full.
// Reset brings the settings to their defaults and empties all state; a bar with
// restart set does the same for the series state.
`timescale 1ns / 1ps

module stochastic_momentum_index (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  smi_bar_if.sink                    bar_in,
  smi_res_if.source                  res_out,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [smi_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import smi_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StCheck = 3'd1;
  localparam logic [2:0] StScan  = 3'd2;
  localparam logic [2:0] StPrep  = 3'd3;
  localparam logic [2:0] StOp    = 3'd4;
  localparam logic [2:0] StSmi   = 3'd5;
  localparam logic [2:0] StDiv   = 3'd6;
  localparam logic [2:0] StOut   = 3'd7;
  localparam logic [2:0] OpLast  = 3'(NumOps - 1);

  cfg_t     cfg;
  win_req_t win_req;
  win_rsp_t win_rsp;

  logic [2:0]  state_q, state_d, op_q, op_d;
  logic [31:0] bar_cnt_q, bar_cnt_d, res_cnt_q, res_cnt_d, rdy_q, rdy_d, idx_q;
  logic [31:0] close_q;
  logic        fin_q, accept, seed_q, seed_d, have_q, have_d, prod_q, prod_d;
  logic [NumOps-1:0] en_q, en_d, lt_q, lt_d, end_q, end_d;
  acc_t        ema_q [NumOps];
  acc_t        ema_d [NumOps];
  sum_t        sum_q [NumOps];
  sum_t        sum_d [NumOps];
  acc_t        num_q, den_q, num_d, den_d, smi_q, smi_d, x, e;
  q16_t        lsmi_q, lsmi_d;
  sum_t        sum_new, div_num, quo;
  logic [8:0]  div_den;
  logic        div_start, div_done, frac_start, frac_done;
  acc_t        frac_res;

  logic [7:0]  s, f, g, p;
  logic [9:0]  ls, lf, lg;
  logic [6:0]  w;
  logic [31:0] m, k;
  logic signed [32:0] hd;
  logic signed [34:0] mv;

  logic        ov_q, ov_d;
  q16_t        o_smi_q, o_sig_q;
  logic [31:0] o_idx_q, o_cnt_q;
  logic        o_fin_q, load;

  smi_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg)
  );

  smi_win u_win (.clk_i, .rst_ni, .req_i(win_req), .rsp_o(win_rsp));

  smi_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(quo)
  );

  smi_frac u_frac (
    .clk_i, .rst_ni, .start_i(frac_start), .num_i(ema_q[2]), .den_i(ema_q[3]),
    .done_o(frac_done), .smi_o(frac_res)
  );

  assign s  = eff_period(cfg.slow_p);
  assign f  = eff_period(cfg.fast_p);
  assign g  = eff_period(cfg.sig_p);
  assign ls = 10'(s) - 10'd1 + 10'(cfg.extra);
  assign lf = 10'(f) - 10'd1 + 10'(cfg.extra);
  assign lg = 10'(g) - 10'd1 + 10'(cfg.extra);
  assign w  = (cfg.win_len == 7'd0) ? 7'd1 :
              (cfg.win_len > 7'(MaxWindow)) ? 7'(MaxWindow) : cfg.win_len;
  assign m  = rdy_q - 32'(ls);
  assign k  = rdy_q - 32'(ls) - 32'(lf);
  assign hd = 33'(win_rsp.high) - 33'(win_rsp.low);
  assign mv = 35'({close_q, 1'b0}) - 35'(win_rsp.high) - 35'(win_rsp.low);

  assign accept         = bar_in.valid && bar_in.ready;
  assign bar_in.ready   = (state_q == StIdle);
  assign win_req.store  = accept;
  assign win_req.clear  = bar_in.restart;
  assign win_req.high   = bar_in.bar_high;
  assign win_req.low    = bar_in.bar_low;
  assign win_req.scan   = (state_q == StCheck) && (win_rsp.fill >= w);
  assign win_req.len    = w;

  always_comb begin
    unique case (op_q)
      3'd0:    begin x = num_q;    p = s; end
      3'd1:    begin x = den_q;    p = s; end
      3'd2:    begin x = ema_q[0]; p = f; end
      3'd3:    begin x = ema_q[1]; p = f; end
      default: begin x = smi_q;    p = g; end
    endcase
  end

  assign e       = ema_q[op_q];
  assign sum_new = sat_add(sum_q[op_q], sum_t'(x));

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    bar_cnt_d  = bar_cnt_q;
    res_cnt_d  = res_cnt_q;
    rdy_d      = rdy_q;
    seed_d     = seed_q;
    have_d     = have_q;
    prod_d     = prod_q;
    en_d       = en_q;
    lt_d       = lt_q;
    end_d      = end_q;
    num_d      = num_q;
    den_d      = den_q;
    smi_d      = smi_q;
    lsmi_d     = lsmi_q;
    ema_d      = ema_q;
    sum_d      = sum_q;
    div_start  = 1'b0;
    div_num    = sum_new;
    div_den    = {1'b0, p};
    frac_start = 1'b0;
    load       = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StCheck;
          if (bar_in.restart) begin
            bar_cnt_d = 32'd1;
            res_cnt_d = '0;
            rdy_d     = '0;
            lsmi_d    = '0;
            for (int i = 0; i < NumOps; i++) begin
              ema_d[i] = '0;
              sum_d[i] = '0;
            end
          end else begin
            bar_cnt_d = bar_cnt_q + 32'd1;
          end
        end
      end
      StCheck: state_d = win_req.scan ? StScan : StIdle;
      StScan: begin
        if (win_rsp.done) begin
          state_d = StPrep;
        end
      end
      StPrep: begin
        if (hd > 33'sd2147483647) begin
          den_d = AccMax;
        end else if (hd < -33'sd2147483648) begin
          den_d = AccMin;
        end else begin
          den_d = {hd[31:0], {FracBits{1'b0}}};
        end
        if (mv > 35'sd2147483647) begin
          num_d = AccMax >>> 1;
        end else if (mv < -35'sd2147483648) begin
          num_d = AccMin >>> 1;
        end else begin
          num_d = {mv[31], mv[31:0], {(FracBits-1){1'b0}}};
        end
        en_d[0]  = 1'b1;
        en_d[1]  = 1'b1;
        lt_d[0]  = rdy_q < 32'(s);
        lt_d[1]  = lt_d[0];
        end_d[0] = rdy_q == 32'(s) - 32'd1;
        end_d[1] = end_d[0];
        en_d[2]  = rdy_q >= 32'(ls);
        en_d[3]  = en_d[2];
        lt_d[2]  = m < 32'(f);
        lt_d[3]  = lt_d[2];
        end_d[2] = m == 32'(f) - 32'd1;
        end_d[3] = end_d[2];
        en_d[4]  = {1'b0, rdy_q} >= 33'(ls + lf);
        lt_d[4]  = k < 32'(g);
        end_d[4] = k == 32'(g) - 32'd1;
        prod_d   = {1'b0, rdy_q} >= 33'(11'(ls) + 11'(lf) + 11'(lg));
        rdy_d    = (rdy_q == '1) ? rdy_q : rdy_q + 32'd1;
        have_d   = 1'b0;
        op_d     = '0;
        state_d  = StOp;
      end
      StOp: begin
        if (!en_q[op_q]) begin
          if (op_q == OpLast) begin
            state_d = StOut;
          end else begin
            op_d = op_q + 3'd1;
          end
        end else if (op_q == OpLast && !have_q) begin
          frac_start = 1'b1;
          state_d    = StSmi;
        end else if (lt_q[op_q]) begin
          sum_d[op_q] = sum_new;
          if (end_q[op_q]) begin
            div_start = 1'b1;
            seed_d    = 1'b1;
            state_d   = StDiv;
          end else if (op_q == OpLast) begin
            state_d = StOut;
          end else begin
            op_d = op_q + 3'd1;
          end
        end else begin
          div_num   = sum_t'(clamp_acc(sum_t'(x) - sum_t'(e))) <<< 1;
          div_den   = 9'(p) + 9'd1;
          div_start = 1'b1;
          seed_d    = 1'b0;
          state_d   = StDiv;
        end
      end
      StSmi: begin
        if (frac_done) begin
          smi_d   = frac_res;
          lsmi_d  = to_q16(frac_res);
          have_d  = 1'b1;
          state_d = StOp;
        end
      end
      StDiv: begin
        if (div_done) begin
          ema_d[op_q] = seed_q ? clamp_acc(quo) : clamp_acc(sum_t'(e) + quo);
          if (op_q == OpLast) begin
            state_d = StOut;
          end else begin
            op_d    = op_q + 3'd1;
            state_d = StOp;
          end
        end
      end
      StOut: begin
        if (!prod_q) begin
          state_d = StIdle;
        end else if (!ov_q || res_out.ready) begin
          load      = 1'b1;
          res_cnt_d = res_cnt_q + 32'd1;
          state_d   = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign ov_d = load || (ov_q && !res_out.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      op_q      <= '0;
      bar_cnt_q <= '0;
      res_cnt_q <= '0;
      rdy_q     <= '0;
      seed_q    <= 1'b0;
      have_q    <= 1'b0;
      prod_q    <= 1'b0;
      en_q      <= '0;
      lt_q      <= '0;
      end_q     <= '0;
      lsmi_q    <= '0;
      ov_q      <= 1'b0;
      for (int i = 0; i < NumOps; i++) begin
        ema_q[i] <= '0;
        sum_q[i] <= '0;
      end
    end else begin
      state_q   <= state_d;
      op_q      <= op_d;
      bar_cnt_q <= bar_cnt_d;
      res_cnt_q <= res_cnt_d;
      rdy_q     <= rdy_d;
      seed_q    <= seed_d;
      have_q    <= have_d;
      prod_q    <= prod_d;
      en_q      <= en_d;
      lt_q      <= lt_d;
      end_q     <= end_d;
      lsmi_q    <= lsmi_d;
      ov_q      <= ov_d;
      ema_q     <= ema_d;
      sum_q     <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    smi_q <= smi_d;
    if (accept) begin
      idx_q   <= bar_in.restart ? '0 : bar_cnt_q;
      close_q <= bar_in.bar_close;
      fin_q   <= bar_in.last_bar;
    end
    if (load) begin
      o_smi_q <= lsmi_q;
      o_sig_q <= to_q16(ema_q[4]);
      o_idx_q <= idx_q;
      o_cnt_q <= res_cnt_d;
      o_fin_q <= fin_q;
    end
  end

  assign res_out.valid       = ov_q;
  assign res_out.smi_line    = o_smi_q;
  assign res_out.signal_line = o_sig_q;
  assign res_out.bar_index   = o_idx_q;
  assign res_out.out_count   = o_cnt_q;
  assign res_out.final_res   = o_fin_q;

endmodule
